// ----- hw/rtl/shabs_pkg.sv -----
package shabs_pkg;

  // Input command codes
  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Widths
  localparam int unsigned WordW    = 32;
  localparam int unsigned PendW    = 6;
  localparam int unsigned LenW     = 64;
  localparam int unsigned BlkCntW  = LenW - PendW - 3;
  localparam int unsigned NumHash  = 8;
  localparam int unsigned NumSched = 16;
  localparam int unsigned NumRound = 64;
  localparam int unsigned RoundW   = 6;

  // First byte of the padding
  localparam logic [7:0] PadMark = 8'h80;
  // First byte position that holds the bit length
  localparam logic [PendW-1:0] LenPos = 6'd56;

  localparam logic [WordW-1:0] HashIv [NumHash] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] RoundK [NumRound] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Input beat
  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_t;

  // Output beat
  typedef struct packed {
    logic [63:0] digest_bits_255_192;
    logic [63:0] digest_bits_191_128;
    logic [63:0] digest_bits_127_64;
    logic [63:0] digest_bits_63_0;
  } out_t;

  // Sequencer to compression core
  typedef struct packed {
    logic       push;
    logic       word_last;
    logic [7:0] push_byte;
    logic       start;
    logic       reinit;
  } core_ctrl_t;

  // Compression core to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage

// ----- hw/rtl/shabs_core.sv -----
module shabs_core
  import shabs_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  core_ctrl_t                 ctrl_i,
  output core_stat_t                 stat_o,
  output logic [NumHash*WordW-1:0]   digest_o
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ROUND = 2'd1;
  localparam logic [1:0] PH_ADD   = 2'd2;

  logic [1:0]        phase_q, phase_d;
  logic [RoundW-1:0] rnd_q, rnd_d;
  logic [WordW-1:0]  h_q [NumHash];
  logic [WordW-1:0]  v_q [NumHash];
  logic [WordW-1:0]  w_q [NumSched];
  logic [23:0]       acc_q;

  logic [WordW-1:0] big_s0, big_s1, ch, maj, t1, t2;
  logic [WordW-1:0] sm_s0, sm_s1, w_new;

  // Round function on the working variables
  always_comb begin
    big_s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1     = v_q[7] + big_s1 + ch + RoundK[rnd_q] + w_q[0];
    big_s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2     = big_s0 + maj;
  end

  // Next schedule word from the window
  always_comb begin
    sm_s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    sm_s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = sm_s1 + w_q[9] + sm_s0 + w_q[0];
  end

  // Sequence the rounds
  always_comb begin
    phase_d = phase_q;
    rnd_d   = rnd_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (ctrl_i.start) begin
          phase_d = PH_ROUND;
          rnd_d   = '0;
        end
      end
      PH_ROUND: begin
        rnd_d = rnd_q + 1'b1;
        if (&rnd_q) begin
          phase_d = PH_ADD;
        end
      end
      PH_ADD:  phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rnd_q   <= '0;
    end else begin
      phase_q <= phase_d;
      rnd_q   <= rnd_d;
    end
  end

  // Chaining value: add the working variables, or load the initial value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumHash; i++) h_q[i] <= HashIv[i];
    end else if (ctrl_i.reinit) begin
      for (int i = 0; i < NumHash; i++) h_q[i] <= HashIv[i];
    end else if (phase_q == PH_ADD) begin
      for (int i = 0; i < NumHash; i++) h_q[i] <= h_q[i] + v_q[i];
    end
  end

  // Working variables: load at start, advance one round per cycle
  always_ff @(posedge clk_i) begin
    if (phase_q == PH_IDLE && ctrl_i.start) begin
      for (int i = 0; i < NumHash; i++) v_q[i] <= h_q[i];
    end else if (phase_q == PH_ROUND) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end
  end

  // Schedule window: filled by bytes, then slid by the rounds
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      acc_q <= {acc_q[15:0], ctrl_i.push_byte};
      if (ctrl_i.word_last) begin
        for (int i = 0; i < NumSched - 1; i++) w_q[i] <= w_q[i+1];
        w_q[NumSched-1] <= {acc_q, ctrl_i.push_byte};
      end
    end else if (phase_q == PH_ROUND) begin
      for (int i = 0; i < NumSched - 1; i++) w_q[i] <= w_q[i+1];
      w_q[NumSched-1] <= w_new;
    end
  end

  assign stat_o.busy = (phase_q != PH_IDLE);
  assign stat_o.done = (phase_q == PH_ADD);

  always_comb begin
    for (int i = 0; i < NumHash; i++) begin
      digest_o[(NumHash-1-i)*WordW +: WordW] = h_q[i];
    end
  end

  a_push_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> phase_q == PH_IDLE)
    else $error("byte pushed during compression");

  a_start_round : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE && ctrl_i.start) |=> (phase_q == PH_ROUND && rnd_q == '0))
    else $error("start did not enter round zero");

  a_add_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ADD |=> phase_q == PH_IDLE)
    else $error("add phase lasted more than one cycle");

endmodule

// ----- hw/rtl/sha256_byte_stream_hash_unit.sv -----
// SHA-256 engine taking one message byte per input beat. Every 64th absorbed
// byte starts a compression of 64 rounds plus one chaining add, during which
// in_stall_o is high. A finish beat clocks the padding in one byte per cycle,
// then runs one compression (two when 56 or more bytes are pending), and
// loads the digest into the output register. The output register holds the
// digest while later bytes are absorbed; a second finish waits until it is
// taken.
module sha256_byte_stream_hash_unit
  import shabs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [PendW-1:0]   pend_q, pend_d;
  logic [BlkCntW-1:0] blk_cnt_q, blk_cnt_d;
  logic [LenW-1:0]    len_q, len_d;
  logic               fin_q, fin_d;
  logic               first_q, first_d;
  logic               last_blk_q, last_blk_d;
  logic               emit_q, emit_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q;
  logic               load_out;
  logic               in_acc;

  core_ctrl_t                 ctrl;
  core_stat_t                 stat;
  logic [NumHash*WordW-1:0]   digest;

  shabs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .stat_o   (stat),
    .digest_o (digest)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Sequencer: absorb, pad, wait on compression, emit
  always_comb begin
    state_d        = state_q;
    pend_d         = pend_q;
    blk_cnt_d      = blk_cnt_q;
    len_d          = len_q;
    fin_d          = fin_q;
    first_d        = first_q;
    last_blk_d     = last_blk_q;
    emit_d         = emit_q;
    load_out       = 1'b0;
    ctrl.push      = 1'b0;
    ctrl.word_last = (pend_q[1:0] == 2'b11);
    ctrl.push_byte = in_data_i.data_byte;
    ctrl.start     = 1'b0;
    ctrl.reinit    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.command == CMD_ABSORB) begin
            ctrl.push = 1'b1;
            pend_d    = pend_q + 1'b1;
            if (&pend_q) begin
              ctrl.start = 1'b1;
              blk_cnt_d  = blk_cnt_q + 1'b1;
              fin_d      = 1'b0;
              state_d    = ST_WAIT;
            end
          end else begin
            len_d      = {blk_cnt_q, pend_q, 3'b000};
            fin_d      = 1'b1;
            first_d    = 1'b1;
            last_blk_d = (pend_q < LenPos);
            state_d    = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctrl.push = 1'b1;
        first_d   = 1'b0;
        if (first_q) begin
          ctrl.push_byte = PadMark;
        end else if (last_blk_q && pend_q >= LenPos) begin
          ctrl.push_byte = len_q[LenW-1 -: 8];
          len_d          = {len_q[LenW-9:0], 8'h00};
        end else begin
          ctrl.push_byte = 8'h00;
        end
        pend_d = pend_q + 1'b1;
        if (&pend_q) begin
          ctrl.start = 1'b1;
          emit_d     = last_blk_q;
          last_blk_d = 1'b1;
          state_d    = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (stat.done) begin
          if (!fin_q) begin
            state_d = ST_IDLE;
          end else if (emit_q) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_PAD;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          ctrl.reinit = 1'b1;
          blk_cnt_d   = '0;
          fin_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register: drop on take, reload on emit
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= '0;
      blk_cnt_q   <= '0;
      fin_q       <= 1'b0;
      first_q     <= 1'b0;
      last_blk_q  <= 1'b0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      blk_cnt_q   <= blk_cnt_d;
      fin_q       <= fin_d;
      first_q     <= first_d;
      last_blk_q  <= last_blk_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    if (load_out) begin
      out_q.digest_bits_255_192 <= digest[255:192];
      out_q.digest_bits_191_128 <= digest[191:128];
      out_q.digest_bits_127_64  <= digest[127:64];
      out_q.digest_bits_63_0    <= digest[63:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_rise_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
    else $error("digest beat appeared outside emit");

  a_start_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.start |-> !stat.busy)
    else $error("compression started while busy");

  a_emit_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> pend_q == '0)
    else $error("emit with bytes pending");

  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> state_q == ST_WAIT)
    else $error("compression finished outside wait");

endmodule

// ----- verif/sha256_byte_stream_hash_unit_tb.sv -----
module sha256_byte_stream_hash_unit_tb
  import shabs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HalfPeriodNs   = 6;
  localparam int ResetCycles    = 9;
  localparam int LongHoldCycles = 900;
  localparam int DrainCycles    = 400;
  localparam int CycleLimit     = 500000;
  localparam int TargetBeats    = 1350;
  localparam int MaxReports     = 10;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // Predictor state: chaining words, block buffer, fill level, bit length
  logic [31:0] chain_h [8];
  logic [7:0]  blk_buf [64];
  logic [5:0]  fill_cnt;
  logic [63:0] msg_bits;

  in_t  beats_to_send [$];
  out_t digests_due [$];

  logic in_beat_taken = 1'b0;
  bit   no_gaps = 1'b0;
  bit   hold_req = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  int   mismatches = 0;
  int   beats_queued = 0;
  longint cycle_count = 0;

  sha256_byte_stream_hash_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #HalfPeriodNs clk_i = ~clk_i;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  // Run one 64-round compression of blk_buf into chain_h
  function automatic void sha_compress_block();
    logic [31:0] w [64];
    logic [31:0] st [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    st = chain_h;
    for (int i = 0; i < 64; i++) begin
      t1 = st[7] + (ror32(st[4], 6) ^ ror32(st[4], 11) ^ ror32(st[4], 25))
         + ((st[4] & st[5]) ^ (~st[4] & st[6])) + ROUND_CONST[i] + w[i];
      t2 = (ror32(st[0], 2) ^ ror32(st[0], 13) ^ ror32(st[0], 22))
         + ((st[0] & st[1]) ^ (st[0] & st[2]) ^ (st[1] & st[2]));
      for (int j = 7; j > 0; j--) begin
        st[j] = st[j-1];
      end
      // st[4] now holds the old d word
      st[4] = st[4] + t1;
      st[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) begin
      chain_h[i] = chain_h[i] + st[i];
    end
  endfunction

  function automatic void sha_restart();
    chain_h  = HASH_INIT;
    fill_cnt = '0;
    msg_bits = '0;
  endfunction

  // Apply one accepted beat; return 1 with the digest when a finish completes
  function automatic bit sha_apply_beat(input in_t beat, output out_t digest);
    logic [5:0] n;
    digest = '0;
    if (beat.command == CMD_ABSORB) begin
      blk_buf[fill_cnt] = beat.data_byte;
      fill_cnt = fill_cnt + 6'd1;
      if (fill_cnt == 6'd0) begin
        sha_compress_block();
        msg_bits = msg_bits + 64'd512;
      end
      return 1'b0;
    end
    n = fill_cnt;
    msg_bits = msg_bits + {55'd0, n, 3'd0};
    blk_buf[n] = PAD_MARK;
    for (int i = n + 1; i < 64; i++) begin
      blk_buf[i] = 8'h00;
    end
    // No room for the length field: flush this block and pad a fresh one
    if (n >= 6'd56) begin
      sha_compress_block();
      for (int i = 0; i < 56; i++) begin
        blk_buf[i] = 8'h00;
      end
    end
    for (int i = 0; i < 8; i++) begin
      blk_buf[56+i] = msg_bits[63-8*i -: 8];
    end
    sha_compress_block();
    digest = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
              chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
    sha_restart();
    return 1'b1;
  endfunction

  function automatic void check_digest(input out_t got);
    out_t want;
    string field_name [4] = '{"digest_bits_255_192", "digest_bits_191_128",
                              "digest_bits_127_64", "digest_bits_63_0"};
    if (digests_due.size() == 0) begin
      if (mismatches < MaxReports) begin
        $display("unexpected digest beat %h", got);
      end
      mismatches++;
      return;
    end
    want = digests_due.pop_front();
    for (int i = 0; i < 4; i++) begin
      if (got[64*(3-i) +: 64] !== want[64*(3-i) +: 64]) begin
        if (mismatches < MaxReports) begin
          $display("%s mismatch: expected %h got %h", field_name[i],
                   want[64*(3-i) +: 64], got[64*(3-i) +: 64]);
        end
        mismatches++;
      end
    end
  endfunction

  task automatic push_beat(input logic cmd, input logic [7:0] data);
    in_t beat;
    beat.command   = cmd;
    beat.data_byte = data;
    beats_to_send.push_back(beat);
    beats_queued++;
  endtask

  // Queue a message of random bytes followed by a finish beat
  task automatic queue_message(input int len);
    for (int i = 0; i < len; i++) begin
      push_beat(CMD_ABSORB, 8'($urandom_range(0, 255)));
    end
    push_beat(CMD_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // Favor short messages and lengths around the padding boundaries
  function automatic int pick_msg_len();
    int unsigned sel;
    int near_pad [6] = '{55, 56, 57, 62, 63, 64};
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      return $urandom_range(0, 8);
    end
    if (sel < 60) begin
      return 64 * $urandom_range(0, 1) + near_pad[$urandom_range(0, 5)];
    end
    if (sel < 90) begin
      return $urandom_range(9, 60);
    end
    return $urandom_range(61, 160);
  endfunction

  task automatic wait_drained();
    while (beats_to_send.size() != 0 || in_valid || digests_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Drive input beats: hold while stalled, then gap or advance
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_beat_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (beats_to_send.size() != 0) begin
        in_data  <= beats_to_send.pop_front();
        in_valid <= 1'b1;
        send_gap = no_gaps ? 0 : $urandom_range(0, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Drive output stall: long hold-off on request, else per-beat stall
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LongHoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      if (out_valid) begin
        stall_left--;
      end
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Sample both channels: predict on input beats, check output beats
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      in_beat_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        if (sha_apply_beat(in_data, want)) begin
          digests_due.push_back(want);
        end
      end
      if (out_valid && !out_stall) begin
        check_digest(out_data);
        stall_left = no_gaps ? 0 : $urandom_range(0, 5);
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("sha256_byte_stream_hash_unit verification failed");
      $finish;
    end
  end

  initial begin
    sha_restart();
    blk_buf = '{default: 8'h00};
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty messages, extreme bytes, "abc", a lone pad-mark byte
    push_beat(CMD_FINISH, 8'h00);
    push_beat(CMD_FINISH, 8'hff);
    push_beat(CMD_ABSORB, 8'h00);
    push_beat(CMD_FINISH, 8'h55);
    push_beat(CMD_ABSORB, 8'hff);
    push_beat(CMD_FINISH, 8'haa);
    push_beat(CMD_ABSORB, 8'h61);
    push_beat(CMD_ABSORB, 8'h62);
    push_beat(CMD_ABSORB, 8'h63);
    push_beat(CMD_FINISH, 8'h00);
    push_beat(CMD_ABSORB, PAD_MARK);
    push_beat(CMD_FINISH, 8'h7f);
    wait_drained();

    // Hold the output back while short messages keep coming, so the
    // digest register fills and the input side stalls
    hold_req = 1'b1;
    no_gaps = 1'b1;
    for (int i = 0; i < 4; i++) begin
      queue_message($urandom_range(1, 6));
    end
    wait_drained();
    no_gaps = 1'b0;

    // Random messages, some phases without idling on either side
    while (beats_queued < TargetBeats) begin
      while (beats_to_send.size() > 200) begin
        @(posedge clk_i);
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      queue_message(pick_msg_len());
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("sha256_byte_stream_hash_unit verification clean");
    end else begin
      $display("sha256_byte_stream_hash_unit verification failed");
    end
    $finish;
  end

endmodule
